// ----- rtl/arp_rgc_pkg.sv -----
// ----------------------------------------------------------------------------
// arp_rgc_pkg - shared types and constants of the ARP responder
// Frame descriptor, register indexes and the beat builder for generated frames.
// ----------------------------------------------------------------------------
`default_nettype none

package arp_rgc_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] CFG_OWN_MAC    = 2'd0;
  localparam logic [1:0] CFG_OWN_IP     = 2'd1;
  localparam logic [1:0] CFG_GATEWAY_IP = 2'd2;
  localparam logic [1:0] CFG_LIFETIME   = 2'd3;

  // Reset values of the registers
  localparam logic [47:0] OWN_MAC_RST    = 48'h0600_0000_0000;
  localparam logic [31:0] OWN_IP_RST     = 32'hC000_0264;
  localparam logic [31:0] GATEWAY_IP_RST = 32'hC000_0201;
  localparam logic [15:0] LIFETIME_RST   = 16'd16;

  // Input op codes
  localparam logic OP_BEAT = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [7:0]  ARP_OP_REQ   = 8'h01;
  localparam logic [15:0] OPC_REQUEST  = 16'h0001;
  localparam logic [15:0] OPC_REPLY    = 16'h0002;
  localparam logic [31:0] W1_TAIL      = 32'h0806_0001;
  localparam logic [31:0] W2_HEAD      = 32'h0800_0604;
  localparam logic [47:0] MAC_BCAST    = 48'hFFFF_FFFF_FFFF;

  localparam int          HIST_DEPTH   = 5;
  localparam int          BEAT_IDX_W   = 3;
  localparam logic [BEAT_IDX_W-1:0] BEAT_FIRST = 3'd0;
  localparam logic [BEAT_IDX_W-1:0] BEAT_LAST  = 3'd5;
  localparam logic [2:0]  EMPTY_LAST   = 3'd6;

  localparam int          QUEUE_DEPTH_DEF = 4;

  // One queued frame: destination (equal to target MAC), kind, target IP and
  // the gateway MAC reported alongside every beat of the frame.
  typedef struct packed {
    logic [47:0] dst_mac;
    logic        is_reply;
    logic [31:0] tgt_ip;
    logic [47:0] gw_mac;
  } frame_desc_t;

  function automatic logic [63:0] build_beat(input frame_desc_t d,
                                             input logic [BEAT_IDX_W-1:0] idx,
                                             input logic [47:0] own_mac,
                                             input logic [31:0] own_ip);
    logic [63:0] w;
    logic [15:0] opc;
    w   = '0;
    opc = d.is_reply ? OPC_REPLY : OPC_REQUEST;
    unique case (idx)
      3'd0:    w = {d.dst_mac, own_mac[47:32]};
      3'd1:    w = {own_mac[31:0], W1_TAIL};
      3'd2:    w = {W2_HEAD, opc, own_mac[47:32]};
      3'd3:    w = {own_mac[31:0], own_ip};
      3'd4:    w = {d.dst_mac, d.tgt_ip[31:16]};
      3'd5:    w = {d.tgt_ip[15:0], 48'h0};
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/arp_rgc_front.sv -----
// ----------------------------------------------------------------------------
// arp_rgc_front - beat history, ARP decode and gateway cache
// Accepts beats and ticks, keeps the cache state and queues frames to send.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_rgc_front import arp_rgc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        accept,
  input  wire logic        op,
  input  wire logic [63:0] beat_data,
  input  wire logic        beat_sop,
  input  wire logic [31:0] own_ip,
  input  wire logic [31:0] gateway_ip,
  input  wire logic [15:0] cache_lifetime,
  output logic             push,
  output frame_desc_t      push_desc
);

  logic [63:0] hist_data_r [HIST_DEPTH];
  logic [HIST_DEPTH-1:0] hist_sop_r;
  logic [47:0] gw_mac_r, gw_mac_nxt;
  logic [15:0] countdown_r, countdown_nxt;

  logic [7:0]  opc;
  logic [47:0] src_mac;
  logic [31:0] src_ip, dst_ip;
  logic        is_arp_pos, for_own, for_gw, from_gw, learn;

  // Fields at fixed places of a frame whose start is five beats back
  assign opc     = hist_data_r[2][23:16];
  assign src_mac = {hist_data_r[2][15:0], hist_data_r[1][63:32]};
  assign src_ip  = hist_data_r[1][31:0];
  assign dst_ip  = {hist_data_r[0][15:0], beat_data[63:48]};

  assign is_arp_pos = (op == OP_BEAT) && hist_sop_r[HIST_DEPTH-1];
  assign for_own    = (dst_ip == own_ip);
  assign for_gw     = (dst_ip == gateway_ip);
  assign from_gw    = (src_ip == gateway_ip);

  always_comb begin
    learn = 1'b0;
    if (is_arp_pos) begin
      if (opc == ARP_OP_REQ) begin
        learn = !for_own && for_gw && from_gw;
      end else begin
        learn = from_gw;
      end
    end
  end

  always_comb begin
    push               = 1'b0;
    push_desc.dst_mac  = MAC_BCAST;
    push_desc.is_reply = 1'b0;
    push_desc.tgt_ip   = gateway_ip;
    push_desc.gw_mac   = gw_mac_r;
    gw_mac_nxt         = gw_mac_r;
    countdown_nxt      = countdown_r;
    if (accept) begin
      if (op == OP_TICK) begin
        if (countdown_r == '0) begin
          push = 1'b1;
        end else begin
          countdown_nxt = countdown_r - 16'd1;
        end
      end else if (is_arp_pos && opc == ARP_OP_REQ && for_own) begin
        push               = 1'b1;
        push_desc.dst_mac  = src_mac;
        push_desc.is_reply = 1'b1;
        push_desc.tgt_ip   = src_ip;
      end else if (learn) begin
        gw_mac_nxt    = src_mac;
        countdown_nxt = cache_lifetime;
      end
    end
  end

  // Shift the history on each accepted beat; data needs no reset since a
  // set start flag in the oldest slot implies every younger slot was written
  always_ff @(posedge clk) begin
    if (accept && op == OP_BEAT) begin
      hist_data_r[0] <= beat_data;
      for (int i = 1; i < HIST_DEPTH; i++) begin
        hist_data_r[i] <= hist_data_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_sop_r  <= '0;
      gw_mac_r    <= '0;
      countdown_r <= '0;
    end else begin
      if (accept && op == OP_BEAT) begin
        hist_sop_r <= {hist_sop_r[HIST_DEPTH-2:0], beat_sop};
      end
      gw_mac_r    <= gw_mac_nxt;
      countdown_r <= countdown_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/arp_rgc_queue.sv -----
// ----------------------------------------------------------------------------
// arp_rgc_queue - frame descriptor queue
// Decouples the decode side from frame serialization.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_rgc_queue import arp_rgc_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire frame_desc_t push_desc,
  input  wire logic        pop,
  output frame_desc_t      head,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  frame_desc_t       slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> !full)
    else $error("queue pushed while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue popped while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

endmodule

`default_nettype wire

// ----- rtl/arp_rgc_back.sv -----
// ----------------------------------------------------------------------------
// arp_rgc_back - frame serializer
// Turns queued descriptors into six-beat frames behind an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_rgc_back import arp_rgc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire frame_desc_t head,
  input  wire logic        q_empty,
  output logic             pop,
  input  wire logic [47:0] own_mac,
  input  wire logic [31:0] own_ip,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_data,
  output logic             out_sop,
  output logic             out_eop,
  output logic [2:0]       out_empty,
  output logic [47:0]      out_gateway_mac_seen
);

  frame_desc_t desc_r, desc_nxt;
  logic        active_r, active_nxt;
  logic [BEAT_IDX_W-1:0] idx_r, idx_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] data_r;
  logic        sop_r, eop_r;
  logic [2:0]  empty_r;
  logic [47:0] gw_r;
  logic        slot_free, adv, last;

  assign slot_free = !out_valid_r || out_ready;
  assign adv       = active_r && slot_free;
  assign last      = (idx_r == BEAT_LAST);
  assign pop       = !q_empty && (!active_r || (adv && last));

  always_comb begin
    desc_nxt      = desc_r;
    active_nxt    = active_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (slot_free) begin
      out_valid_nxt = active_r;
    end
    if (adv) begin
      idx_nxt = last ? BEAT_FIRST : idx_r + BEAT_IDX_W'(1);
      if (last) begin
        active_nxt = 1'b0;
      end
    end
    if (pop) begin
      desc_nxt   = head;
      active_nxt = 1'b1;
      idx_nxt    = BEAT_FIRST;
    end
  end

  // Output payload loads only when a new beat enters the register
  always_ff @(posedge clk) begin
    desc_r <= desc_nxt;
    if (adv) begin
      data_r  <= build_beat(desc_r, idx_r, own_mac, own_ip);
      sop_r   <= (idx_r == BEAT_FIRST);
      eop_r   <= last;
      empty_r <= last ? EMPTY_LAST : 3'd0;
      gw_r    <= desc_r.gw_mac;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      idx_r       <= BEAT_FIRST;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_data             = data_r;
  assign out_sop              = sop_r;
  assign out_eop              = eop_r;
  assign out_empty            = empty_r;
  assign out_gateway_mac_seen = gw_r;

  a_frame_unbroken: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ready && !eop_r |=> out_valid_r && !sop_r)
    else $error("gap inside a generated frame");

  a_eop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (eop_r == (empty_r == EMPTY_LAST)) && !(sop_r && eop_r))
    else $error("frame markers inconsistent");

endmodule

`default_nettype wire

// ----- rtl/arp_responder_gateway_cache.sv -----
// A reply or refresh request passes the frame queue, descriptor register and
// output register; its six beats then leave one per cycle while out_ready holds.
// Throughput: one input item per cycle while the frame queue has a free slot;
// the queue holds QUEUE_DEPTH frames; serializer drains one beat a cycle while
// out_ready holds. Reset (synchronous, rst_n low): history flags, gateway MAC,
// countdown, queue, output stage clear; registers get defaults. No clearing pass.
// ----------------------------------------------------------------------------
// arp_responder_gateway_cache - ARP responder with gateway MAC cache
// Answers ARP requests for the own IP, learns the gateway MAC and refreshes it
// with broadcast requests driven by one-second ticks.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_responder_gateway_cache import arp_rgc_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [47:0] cfg_data,
  // input channel: packet beats and ticks
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_op,
  input  wire logic [63:0] in_beat_data,
  input  wire logic        in_beat_sop,
  // result channel: generated frame beats
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_data,
  output logic             out_sop,
  output logic             out_eop,
  output logic [2:0]       out_empty,
  output logic [47:0]      out_gateway_mac_seen
);

  // Config regs: written only while the block is idle, a user duty left unchecked
  logic [47:0] own_mac_r;
  logic [31:0] own_ip_r;
  logic [31:0] gateway_ip_r;
  logic [15:0] lifetime_r;

  logic        in_xfer;
  logic        push, pop, q_full, q_empty;
  frame_desc_t push_desc, head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_mac_r    <= OWN_MAC_RST;
      own_ip_r     <= OWN_IP_RST;
      gateway_ip_r <= GATEWAY_IP_RST;
      lifetime_r   <= LIFETIME_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_OWN_MAC:    own_mac_r    <= cfg_data;
        CFG_OWN_IP:     own_ip_r     <= cfg_data[31:0];
        CFG_GATEWAY_IP: gateway_ip_r <= cfg_data[31:0];
        CFG_LIFETIME:   lifetime_r   <= cfg_data[15:0];
        default:        ;
      endcase
    end
  end

  // Hold off the input only when the frame queue has no room; every item may
  // queue at most one frame, so a free slot covers any item.
  assign in_ready = !q_full;
  assign in_xfer  = in_valid && in_ready;

  // Front: history, decode, gateway cache and refresh countdown
  arp_rgc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (in_xfer),
    .op             (in_op),
    .beat_data      (in_beat_data),
    .beat_sop       (in_beat_sop),
    .own_ip         (own_ip_r),
    .gateway_ip     (gateway_ip_r),
    .cache_lifetime (lifetime_r),
    .push           (push),
    .push_desc      (push_desc)
  );

  // Queue of frames waiting for the serializer
  arp_rgc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Back: advance one beat per transfer on the result channel
  arp_rgc_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .head                 (head),
    .q_empty              (q_empty),
    .pop                  (pop),
    .own_mac              (own_mac_r),
    .own_ip               (own_ip_r),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_data             (out_data),
    .out_sop              (out_sop),
    .out_eop              (out_eop),
    .out_empty            (out_empty),
    .out_gateway_mac_seen (out_gateway_mac_seen)
  );

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - ARP responder with gateway cache
// Sends ARP frames, junk beats and one-second ticks under random gaps and
// output stalls. A local model predicts every generated frame beat, and each
// transfer on the result channel is checked against it in order.
// ----------------------------------------------------------------------------

module testbench;
  import arp_rgc_pkg::*;

  typedef logic [5:0][63:0] frame_t;

  typedef struct packed {
    logic [63:0] data;
    logic        sop;
    logic        eop;
    logic [2:0]  empty;
    logic [47:0] gw_mac;
  } tx_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [47:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic        in_op;
  logic [63:0] in_beat_data;
  logic        in_beat_sop;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] out_data;
  logic        out_sop;
  logic        out_eop;
  logic [2:0]  out_empty;
  logic [47:0] out_gateway_mac_seen;

  // Register shadow and decoder state of the local model
  logic [47:0] reg_own_mac;
  logic [31:0] reg_own_ip;
  logic [31:0] reg_gw_ip;
  logic [15:0] reg_lifetime;
  logic [63:0] hist_data [HIST_DEPTH];
  logic        hist_sop  [HIST_DEPTH];
  logic [47:0] learned_gw_mac;
  logic [15:0] refresh_left;

  // Frame beats still owed by the block, oldest first
  tx_beat_t beats_due [$];

  // Knobs shared between the stimulus thread and the receiver
  bit in_gaps_on;
  bit out_stalls_on;
  bit hold_request;
  int hold_cycles;

  int mismatches;
  int items_sent;
  int ticks_sent;
  int beats_checked;
  int in_stall_cycles;
  int settings_used;

  arp_responder_gateway_cache dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_op                (in_op),
    .in_beat_data         (in_beat_data),
    .in_beat_sop          (in_beat_sop),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_data             (out_data),
    .out_sop              (out_sop),
    .out_eop              (out_eop),
    .out_empty            (out_empty),
    .out_gateway_mac_seen (out_gateway_mac_seen)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Model of the block
  // --------------------------------------------------------------------------

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Queue the six beats of one generated frame. Destination and target MAC
  // are always the same address: the requester for a reply, broadcast for a
  // refresh request. Every beat carries the gateway MAC held right now.
  task automatic queue_generated_frame(input logic [47:0] dst_mac,
                                       input logic [15:0] opcode,
                                       input logic [31:0] tgt_ip);
    logic [63:0] w [6];
    tx_beat_t    b;
    w[0] = {dst_mac, reg_own_mac[47:32]};
    w[1] = {reg_own_mac[31:0], W1_TAIL};
    w[2] = {W2_HEAD, opcode, reg_own_mac[47:32]};
    w[3] = {reg_own_mac[31:0], reg_own_ip};
    w[4] = {dst_mac, tgt_ip[31:16]};
    w[5] = {tgt_ip[15:0], 48'h0};
    for (int k = 0; k < 6; k++) begin
      b.data   = w[k];
      b.sop    = (k == 0);
      b.eop    = (k == 5);
      b.empty  = (k == 5) ? EMPTY_LAST : 3'd0;
      b.gw_mac = learned_gw_mac;
      beats_due.push_back(b);
    end
  endtask

  // Advance the model by one accepted input transfer.
  task automatic predict_arp_item(input logic op, input logic [63:0] beat,
                                  input logic sop);
    logic [7:0]  opc;
    logic [47:0] src_mac;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    if (op == OP_TICK) begin
      // At zero the countdown holds and a refresh goes out on every tick
      if (refresh_left == 16'd0) begin
        queue_generated_frame(MAC_BCAST, OPC_REQUEST, reg_gw_ip);
      end else begin
        refresh_left = refresh_left - 16'd1;
      end
      return;
    end
    // Sixth beat of a frame: decode fixed offsets, no ethertype check
    if (hist_sop[4]) begin
      opc     = hist_data[2][23:16];
      src_mac = {hist_data[2][15:0], hist_data[1][63:32]};
      src_ip  = hist_data[1][31:0];
      dst_ip  = {hist_data[0][15:0], beat[63:48]};
      if (opc == ARP_OP_REQ) begin
        // A request for our own IP wins even when the gateway asks
        if (dst_ip == reg_own_ip) begin
          queue_generated_frame(src_mac, OPC_REPLY, src_ip);
        end else if (dst_ip == reg_gw_ip && src_ip == reg_gw_ip) begin
          learned_gw_mac = src_mac;
          refresh_left   = reg_lifetime;
        end
      end else if (src_ip == reg_gw_ip) begin
        learned_gw_mac = src_mac;
        refresh_left   = reg_lifetime;
      end
    end
    for (int i = HIST_DEPTH - 1; i > 0; i--) begin
      hist_data[i] = hist_data[i-1];
      hist_sop[i]  = hist_sop[i-1];
    end
    hist_data[0] = beat;
    hist_sop[0]  = sop;
  endtask

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Offer one item and hold it until the transfer; valid stays high after
  // the transfer so that back-to-back items keep it up.
  task automatic send_item(input logic op, input logic [63:0] data,
                           input logic sop);
    if (in_gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_op        <= op;
    in_beat_data <= data;
    in_beat_sop  <= sop;
    do begin
      @(posedge clk);
      if (!in_ready) in_stall_cycles++;
    end while (!in_ready);
    predict_arp_item(op, data, sop);
    items_sent++;
    if (op == OP_TICK) ticks_sent++;
  endtask

  task automatic send_tick();
    send_item(OP_TICK, rand64(), 1'($urandom_range(0, 1)));
  endtask

  // Send the given number of beats of a frame; optionally slip ticks in between
  // beats, which must not disturb the beat history.
  task automatic send_frame(input frame_t f, input int beats, input bit mix_ticks);
    for (int k = 0; k < beats; k++) begin
      if (mix_ticks && $urandom_range(0, 9) == 0) send_tick();
      send_item(OP_BEAT, f[k], k == 0);
    end
  endtask

  function automatic frame_t make_arp_frame(input logic [7:0] opc,
                                            input logic [47:0] smac,
                                            input logic [31:0] sip,
                                            input logic [31:0] tip);
    frame_t f;
    f[0] = rand64();
    f[1] = {$urandom, W1_TAIL};
    f[2] = {W2_HEAD, 8'h00, opc, smac[47:32]};
    f[3] = {smac[31:0], sip};
    f[4] = {48'(rand64()), tip[31:16]};
    f[5] = {tip[15:0], 48'(rand64())};
    return f;
  endfunction

  // Drop valid, wait until every owed beat is out, then let the pipeline
  // settle, since a learning beat produces nothing to wait for.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [47:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_OWN_MAC:    reg_own_mac  = value;
      CFG_OWN_IP:     reg_own_ip   = value[31:0];
      CFG_GATEWAY_IP: reg_gw_ip    = value[31:0];
      CFG_LIFETIME:   reg_lifetime = value[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Write all four registers; the unused upper bits of the narrow ones get
  // random data so every bit of the write bus toggles.
  task automatic configure_regs(input logic [47:0] mac, input logic [31:0] own_ip,
                                input logic [31:0] gw_ip, input logic [15:0] lifetime);
    drain_results();
    write_reg(CFG_OWN_MAC, mac);
    write_reg(CFG_OWN_IP, {16'($urandom), own_ip});
    write_reg(CFG_GATEWAY_IP, {16'($urandom), gw_ip});
    write_reg(CFG_LIFETIME, {32'($urandom), lifetime});
    settings_used++;
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stall bursts, plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
      end else if (out_stalls_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    tx_beat_t b;
    if (rst_n && out_valid && out_ready) begin
      if (beats_due.size() == 0) begin
        $display("%0t: unexpected frame beat, expected none, got %h",
                 $time, out_data);
        mismatches++;
      end else begin
        b = beats_due.pop_front();
        check_field("out_data", b.data, out_data);
        check_field("out_sop", 64'(b.sop), 64'(out_sop));
        check_field("out_eop", 64'(b.eop), 64'(out_eop));
        check_field("out_empty", 64'(b.empty), 64'(out_empty));
        check_field("out_gateway_mac_seen", 64'(b.gw_mac),
                    64'(out_gateway_mac_seen));
        beats_checked++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Countdown is zero after reset, so the first tick sends a refresh request
  task automatic test_refresh_after_reset();
    send_item(OP_TICK, 64'h0, 1'b0);
  endtask

  // Gateway asks for our IP: answer it, leave the cache alone, so the next
  // tick still finds the countdown at zero
  task automatic test_reply_to_own_ip();
    send_frame(make_arp_frame(ARP_OP_REQ, 48'(rand64()), reg_gw_ip, reg_own_ip),
               6, 1'b0);
    send_item(OP_TICK, '1, 1'b1);
  endtask

  // All-ones frame: opcode is not a request and the sender is not the gateway
  task automatic test_ignored_frame();
    send_frame('1, 6, 1'b0);
  endtask

  // Gratuitous ARP from the gateway, then a tick that only counts down, then
  // a gateway reply with a fresh MAC
  task automatic test_gateway_learning();
    send_frame(make_arp_frame(ARP_OP_REQ, '1, reg_gw_ip, reg_gw_ip), 6, 1'b0);
    send_tick();
    send_frame(make_arp_frame(OPC_REPLY[7:0], 48'(rand64()), reg_gw_ip,
                              32'($urandom)),
               6, 1'b0);
  endtask

  // Hold the receiver off for a long stretch while own-IP requests keep
  // coming, so the frame queue fills and the input stalls
  task automatic test_backpressure();
    drain_results();
    hold_cycles  = 300;
    hold_request = 1'b1;
    for (int n = 0; n < 8; n++) begin
      send_frame(make_arp_frame(ARP_OP_REQ, 48'(rand64()), $urandom, reg_own_ip),
                 6, 1'b0);
    end
  endtask

  // ARP frames with random content for half the picks, mixed with ticks,
  // junk beats, truncated frames and non-ARP frames
  task automatic test_random_traffic(input int count);
    int          start;
    int          pick;
    logic [7:0]  opc;
    logic [31:0] sip;
    logic [31:0] tip;
    frame_t      f;
    start = items_sent;
    while (items_sent - start < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        case ($urandom_range(0, 5))
          0, 1, 2: opc = ARP_OP_REQ;
          3, 4:    opc = OPC_REPLY[7:0];
          default: opc = 8'($urandom);
        endcase
        sip = ($urandom_range(0, 1) == 0) ? reg_gw_ip : $urandom;
        case ($urandom_range(0, 3))
          0, 1:    tip = reg_own_ip;
          2:       tip = reg_gw_ip;
          default: tip = $urandom;
        endcase
        send_frame(make_arp_frame(opc, 48'(rand64()), sip, tip), 6, 1'b1);
      end else if (pick < 62) begin
        send_tick();
      end else if (pick < 77) begin
        send_item(OP_BEAT, rand64(), $urandom_range(0, 3) == 0);
      end else if (pick < 90) begin
        f = make_arp_frame(ARP_OP_REQ, 48'(rand64()), reg_gw_ip, reg_own_ip);
        send_frame(f, $urandom_range(1, 5), 1'b1);
      end else begin
        for (int k = 0; k < 6; k++) f[k] = rand64();
        send_frame(f, 6, 1'b0);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    cfg_valid     = 1'b0;
    cfg_index     = CFG_OWN_MAC;
    cfg_data      = '0;
    in_valid      = 1'b0;
    in_op         = OP_BEAT;
    in_beat_data  = '0;
    in_beat_sop   = 1'b0;
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
    hold_request  = 1'b0;
    hold_cycles   = 0;
    mismatches    = 0;
    items_sent    = 0;
    ticks_sent    = 0;
    beats_checked = 0;
    in_stall_cycles = 0;
    settings_used = 1;

    reg_own_mac    = OWN_MAC_RST;
    reg_own_ip     = OWN_IP_RST;
    reg_gw_ip      = GATEWAY_IP_RST;
    reg_lifetime   = LIFETIME_RST;
    learned_gw_mac = '0;
    refresh_left   = '0;
    for (int i = 0; i < HIST_DEPTH; i++) begin
      hist_data[i] = '0;
      hist_sop[i]  = 1'b0;
    end

    // Hold reset, then release it
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed checks run on the reset register values
    test_refresh_after_reset();
    test_reply_to_own_ip();
    test_ignored_frame();
    test_gateway_learning();
    test_backpressure();

    // Random traffic across several register settings, extremes included
    configure_regs(48'(rand64()), $urandom, $urandom, 16'd2);
    test_random_traffic(25);
    configure_regs('1, '1, '1, 16'hFFFF);
    test_random_traffic(20);
    configure_regs('0, '0, '0, 16'd0);
    test_random_traffic(25);

    // Last stretch: no gaps on either side
    configure_regs(48'(rand64()), $urandom, $urandom, 16'd1);
    in_gaps_on    = 1'b0;
    out_stalls_on = 1'b0;
    test_random_traffic(25);

    drain_results();
    repeat (10) @(posedge clk);

    $display("Run covered %0d input transfers (%0d ticks) over %0d register settings,",
             items_sent, ticks_sent, settings_used);
    $display("%0d generated frame beats checked, %0d cycles of input held off.",
             beats_checked, in_stall_cycles);
    if (mismatches == 0 && beats_due.size() == 0) begin
      $display("arp_responder_gateway_cache verification clean");
    end else begin
      $display("arp_responder_gateway_cache verification failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("arp_responder_gateway_cache verification failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/arp_rgc_pkg.sv
rtl/arp_rgc_front.sv
rtl/arp_rgc_queue.sv
rtl/arp_rgc_back.sv
rtl/arp_responder_gateway_cache.sv
sim/testbench.sv
